// ===== hw/rtl/pdh_pkg.sv =====
// Shared types and constants of the pair distance histogram unit.
package pdh_pkg;

   localparam int COORD_W   = 24;
   localparam int RADIUS_W  = 23;
   localparam int BUDGET_W  = 32;
   localparam int COUNT_W   = 32;
   localparam int BIN_IDX_W = 6;
   localparam int IGNORED_W = 11;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_OP_W   = 30;
   localparam int ACC_W     = 2 * SQ_OP_W + 2;
   localparam int D2_W      = 2 * DIFF_W + 2;
   localparam int MAXSQ_W   = 2 * RADIUS_W;

   localparam logic [RADIUS_W-1:0] MAX_RADIUS_RESET = 23'd2560;
   localparam logic [RADIUS_W-1:0] BIN_WIDTH_RESET  = 23'd256;
   localparam logic [BUDGET_W-1:0] PAIR_BUDGET_RESET = 32'd1048576;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } pdh_opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RADIUS     = 2'd0,
      CSR_BIN_WIDTH      = 2'd1,
      CSR_SAME_SELECTION = 2'd2,
      CSR_PAIR_BUDGET    = 2'd3
   } pdh_csr_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_CONFIG = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_NO_PAIRS   = 3'd3,
      ST_BUDGET     = 3'd4
   } pdh_status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
      logic                      second;
      logic                      first;
   } pdh_atom_type;

   typedef struct packed {
      logic en;
      logic add;
   } pdh_mac_cmd_type;

endpackage

// ===== hw/rtl/pdh_if.sv =====
// Request and response channel interfaces of the pair distance histogram unit.
interface pdh_req_if;
   import pdh_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic                      in_first;
   logic                      in_second;
   logic                      present;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, in_first, in_second,
                   present, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, pos_z, in_first, in_second,
                 present, output ready);
endinterface

interface pdh_rsp_if;
   import pdh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BIN_IDX_W-1:0] bin_index;
   logic [COUNT_W-1:0]   bin_count;
   logic [STATUS_W-1:0]  status;
   logic [COUNT_W-1:0]   evaluated_pairs;
   logic [IGNORED_W-1:0] ignored_atoms;
   logic                 last;

   modport source (output valid, bin_index, bin_count, status, evaluated_pairs,
                   ignored_atoms, last, input ready);
   modport sink (input valid, bin_index, bin_count, status, evaluated_pairs,
                 ignored_atoms, last, output ready);
endinterface

// ===== hw/rtl/pdh_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pdh_mac.sv =====
// Shared squaring unit with a load or accumulate result register.
module pdh_mac (
   input  logic                                clock,
   input  pdh_pkg::pdh_mac_cmd_type            cmd,
   input  logic [pdh_pkg::SQ_OP_W-1:0]         operand,
   output logic [pdh_pkg::ACC_W-1:0]           acc
);
   import pdh_pkg::*;

   logic [2*SQ_OP_W-1:0] prod;
   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     acc_in;

   assign prod = operand * operand;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.en) begin
         acc_in = cmd.add ? (acc_ff + ACC_W'(prod)) : ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/pair_distance_histogram_unit.sv =====
// Top level of the pair distance histogram unit: atom store, pair sequencer and bin emit.
// A load item leaves the unit idle, so atoms stream in back to back. A compute item holds
// the request side until its last result transfers: a configuration check that counts
// the bins, then a walk over the outer atoms and, for each first-selection atom, over the
// inner atoms; each evaluated pair is squared and held to the cutoff and, inside it, to
// the bin-edge squares in turn before its bin is updated; then the histogram bins are
// emitted. This sequence follows from the single read port of the atom store and the one
// squaring unit that serves distance, cutoff and bin-edge squares in turn.
module pair_distance_histogram_unit #(
   parameter int MAX_ATOMS = 1024,
   parameter int MAX_BINS  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   pdh_req_if.sink                           req_port,
   pdh_rsp_if.source                         rsp_port,
   input  logic                              csr_we,
   input  logic [pdh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pdh_pkg::*;

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NW = $clog2(MAX_BINS + 1);
   localparam int ATOM_W = $bits(pdh_atom_type);

   typedef enum logic [18:0] {
      S_IDLE = 19'h00001,
      S_CFG  = 19'h00002,
      S_NB   = 19'h00004,
      S_SEL  = 19'h00008,
      S_MSQ  = 19'h00010,
      S_IRD  = 19'h00020,
      S_ILAT = 19'h00040,
      S_JRD  = 19'h00080,
      S_JCHK = 19'h00100,
      S_SQY  = 19'h00200,
      S_SQZ  = 19'h00400,
      S_DCMP = 19'h00800,
      S_BSQ  = 19'h01000,
      S_BCMP = 19'h02000,
      S_HRD  = 19'h04000,
      S_HWR  = 19'h08000,
      S_ORD  = 19'h10000,
      S_OUT  = 19'h20000,
      S_ERR  = 19'h40000
   } state_type;

   state_type            state_ff, state_in;
   logic [RADIUS_W-1:0]  mr_ff, mr_in;
   logic [RADIUS_W-1:0]  bw_ff, bw_in;
   logic                 same_ff, same_in;
   logic [BUDGET_W-1:0]  budget_ff, budget_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        missing_ff, missing_in;
   logic                 has_first_ff, has_first_in;
   logic                 has_second_ff, has_second_in;
   logic [SQ_OP_W-1:0]   nb_acc_ff, nb_acc_in;
   logic [NW-1:0]        nbins_ff, nbins_in;
   logic [AW-1:0]        i_ff, i_in;
   logic [AW-1:0]        j_ff, j_in;
   logic [COORD_W-1:0]   xi_ff, xi_in, yi_ff, yi_in, zi_ff, zi_in;
   logic [DIFF_W-1:0]    dy_ff, dy_in, dz_ff, dz_in;
   logic [COUNT_W-1:0]   pairs_ff, pairs_in;
   logic [MAXSQ_W-1:0]   maxsq_ff, maxsq_in;
   logic [D2_W-1:0]      d2_ff, d2_in;
   logic [BW-1:0]        k_ff, k_in;
   logic [SQ_OP_W-1:0]   edge_ff, edge_in;
   logic [MAX_BINS-1:0]  hv_ff, hv_in;
   pdh_status_type       status_ff, status_in;

   pdh_mac_cmd_type      mac_cmd;
   logic [SQ_OP_W-1:0]   mac_operand;
   logic [ACC_W-1:0]     mac_acc;

   logic                 atom_we;
   pdh_atom_type         atom_wdata;
   logic                 atom_re;
   logic [AW-1:0]        atom_raddr;
   logic [ATOM_W-1:0]    atom_rdata;
   pdh_atom_type         atom_rd;

   logic                 hist_we;
   logic [COUNT_W-1:0]   hist_wdata;
   logic                 hist_re;
   logic [BW-1:0]        hist_raddr;
   logic [COUNT_W-1:0]   hist_rdata;
   logic [COUNT_W-1:0]   hist_value;

   logic                 adv_j, adv_i, finish;
   logic                 req_xfer, rsp_xfer;
   logic signed [DIFF_W-1:0] dxs, dys, dzs;
   logic [DIFF_W-1:0]    dxa;

   assign atom_rd  = pdh_atom_type'(atom_rdata);
   assign req_xfer = req_port.valid && req_port.ready;
   assign rsp_xfer = rsp_port.valid && rsp_port.ready;
   assign hist_value = hv_ff[k_ff] ? hist_rdata : '0;

   assign dxs = {atom_rd.x[COORD_W-1], atom_rd.x} - {xi_ff[COORD_W-1], xi_ff};
   assign dys = {atom_rd.y[COORD_W-1], atom_rd.y} - {yi_ff[COORD_W-1], yi_ff};
   assign dzs = {atom_rd.z[COORD_W-1], atom_rd.z} - {zi_ff[COORD_W-1], zi_ff};
   assign dxa = dxs[DIFF_W-1] ? DIFF_W'(-dxs) : DIFF_W'(dxs);

   always_comb begin
      state_in      = state_ff;
      mr_in         = mr_ff;
      bw_in         = bw_ff;
      same_in       = same_ff;
      budget_in     = budget_ff;
      total_in      = total_ff;
      missing_in    = missing_ff;
      has_first_in  = has_first_ff;
      has_second_in = has_second_ff;
      nb_acc_in     = nb_acc_ff;
      nbins_in      = nbins_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      xi_in         = xi_ff;
      yi_in         = yi_ff;
      zi_in         = zi_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      pairs_in      = pairs_ff;
      maxsq_in      = maxsq_ff;
      d2_in         = d2_ff;
      k_in          = k_ff;
      edge_in       = edge_ff;
      hv_in         = hv_ff;
      status_in     = status_ff;
      mac_cmd       = '0;
      mac_operand   = '0;
      atom_we       = 1'b0;
      atom_wdata    = '0;
      atom_re       = 1'b0;
      atom_raddr    = i_ff;
      hist_we       = 1'b0;
      hist_wdata    = hist_value + COUNT_W'(1);
      hist_re       = 1'b0;
      hist_raddr    = k_ff;
      adv_j         = 1'b0;
      adv_i         = 1'b0;
      finish        = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_RADIUS:     mr_in = csr_wdata[RADIUS_W-1:0];
            CSR_BIN_WIDTH:      bw_in = csr_wdata[RADIUS_W-1:0];
            CSR_SAME_SELECTION: same_in = csr_wdata[0];
            CSR_PAIR_BUDGET:    budget_in = csr_wdata[BUDGET_W-1:0];
            default:            mr_in = mr_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_port.opcode == OP_LOAD) begin
                  if (total_ff < CW'(MAX_ATOMS)) begin
                     atom_we           = 1'b1;
                     atom_wdata.x      = req_port.pos_x;
                     atom_wdata.y      = req_port.pos_y;
                     atom_wdata.z      = req_port.pos_z;
                     atom_wdata.first  = req_port.in_first && req_port.present;
                     atom_wdata.second = req_port.in_second && req_port.present;
                     has_first_in  = has_first_ff || atom_wdata.first;
                     has_second_in = has_second_ff || atom_wdata.second;
                     if ((req_port.in_first || req_port.in_second) && !req_port.present) begin
                        missing_in = missing_ff + CW'(1);
                     end
                     total_in = total_ff + CW'(1);
                  end
               end else begin
                  pairs_in = '0;
                  state_in = S_CFG;
               end
            end
         end
         S_CFG: begin
            if (mr_ff == '0 || bw_ff == '0 || budget_ff == '0 || bw_ff > mr_ff) begin
               status_in = ST_BAD_CONFIG;
               state_in  = S_ERR;
            end else begin
               nb_acc_in = SQ_OP_W'(bw_ff);
               nbins_in  = NW'(1);
               state_in  = S_NB;
            end
         end
         S_NB: begin
            if (nb_acc_ff >= SQ_OP_W'(mr_ff)) begin
               state_in = S_SEL;
            end else if (nbins_ff == NW'(MAX_BINS)) begin
               status_in = ST_BAD_CONFIG;
               state_in  = S_ERR;
            end else begin
               nb_acc_in = nb_acc_ff + SQ_OP_W'(bw_ff);
               nbins_in  = nbins_ff + NW'(1);
            end
         end
         S_SEL: begin
            if (!has_first_ff || !has_second_ff) begin
               status_in = ST_EMPTY;
               state_in  = S_ERR;
            end else begin
               mac_cmd.en  = 1'b1;
               mac_operand = SQ_OP_W'(mr_ff);
               hv_in       = '0;
               i_in        = '0;
               state_in    = S_MSQ;
            end
         end
         S_MSQ: begin
            maxsq_in = mac_acc[MAXSQ_W-1:0];
            state_in = S_IRD;
         end
         S_IRD: begin
            atom_re    = 1'b1;
            atom_raddr = i_ff;
            state_in   = S_ILAT;
         end
         S_ILAT: begin
            if (atom_rd.first) begin
               xi_in    = atom_rd.x;
               yi_in    = atom_rd.y;
               zi_in    = atom_rd.z;
               j_in     = '0;
               state_in = S_JRD;
            end else begin
               adv_i = 1'b1;
            end
         end
         S_JRD: begin
            atom_re    = 1'b1;
            atom_raddr = j_ff;
            state_in   = S_JCHK;
         end
         S_JCHK: begin
            if (!atom_rd.second || i_ff == j_ff || (same_ff && i_ff > j_ff)) begin
               adv_j = 1'b1;
            end else if (pairs_ff == budget_ff) begin
               status_in = ST_BUDGET;
               state_in  = S_ERR;
            end else begin
               pairs_in    = pairs_ff + COUNT_W'(1);
               dy_in       = dys[DIFF_W-1] ? DIFF_W'(-dys) : DIFF_W'(dys);
               dz_in       = dzs[DIFF_W-1] ? DIFF_W'(-dzs) : DIFF_W'(dzs);
               mac_cmd.en  = 1'b1;
               mac_operand = SQ_OP_W'(dxa);
               state_in    = S_SQY;
            end
         end
         S_SQY: begin
            mac_cmd.en  = 1'b1;
            mac_cmd.add = 1'b1;
            mac_operand = SQ_OP_W'(dy_ff);
            state_in    = S_SQZ;
         end
         S_SQZ: begin
            mac_cmd.en  = 1'b1;
            mac_cmd.add = 1'b1;
            mac_operand = SQ_OP_W'(dz_ff);
            state_in    = S_DCMP;
         end
         S_DCMP: begin
            d2_in = mac_acc[D2_W-1:0];
            if (mac_acc < ACC_W'(maxsq_ff)) begin
               k_in     = '0;
               edge_in  = SQ_OP_W'(bw_ff);
               state_in = S_BSQ;
            end else begin
               adv_j = 1'b1;
            end
         end
         S_BSQ: begin
            mac_cmd.en  = 1'b1;
            mac_operand = edge_ff;
            state_in    = S_BCMP;
         end
         S_BCMP: begin
            if (ACC_W'(d2_ff) >= mac_acc && (NW'(k_ff) + NW'(1)) < nbins_ff) begin
               k_in     = k_ff + BW'(1);
               edge_in  = edge_ff + SQ_OP_W'(bw_ff);
               state_in = S_BSQ;
            end else begin
               state_in = S_HRD;
            end
         end
         S_HRD: begin
            hist_re    = 1'b1;
            hist_raddr = k_ff;
            state_in   = S_HWR;
         end
         S_HWR: begin
            hist_we      = 1'b1;
            hv_in[k_ff]  = 1'b1;
            adv_j        = 1'b1;
         end
         S_ORD: begin
            hist_re    = 1'b1;
            hist_raddr = k_ff;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_xfer) begin
               if ((NW'(k_ff) + NW'(1)) == nbins_ff) begin
                  finish = 1'b1;
               end else begin
                  k_in     = k_ff + BW'(1);
                  state_in = S_ORD;
               end
            end
         end
         S_ERR: begin
            if (rsp_xfer) begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (adv_j) begin
         if ((CW'(j_ff) + CW'(1)) == total_ff) begin
            adv_i = 1'b1;
         end else begin
            j_in     = j_ff + AW'(1);
            state_in = S_JRD;
         end
      end

      if (adv_i) begin
         if ((CW'(i_ff) + CW'(1)) == total_ff) begin
            if (pairs_ff == '0) begin
               status_in = ST_NO_PAIRS;
               state_in  = S_ERR;
            end else begin
               status_in = ST_OK;
               k_in      = '0;
               state_in  = S_ORD;
            end
         end else begin
            i_in     = i_ff + AW'(1);
            state_in = S_IRD;
         end
      end

      if (finish) begin
         total_in      = '0;
         missing_in    = '0;
         has_first_in  = 1'b0;
         has_second_in = 1'b0;
         state_in      = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mr_ff         <= MAX_RADIUS_RESET;
         bw_ff         <= BIN_WIDTH_RESET;
         same_ff       <= 1'b0;
         budget_ff     <= PAIR_BUDGET_RESET;
         total_ff      <= '0;
         missing_ff    <= '0;
         has_first_ff  <= 1'b0;
         has_second_ff <= 1'b0;
         pairs_ff      <= '0;
         hv_ff         <= '0;
         status_ff     <= ST_OK;
      end else begin
         state_ff      <= state_in;
         mr_ff         <= mr_in;
         bw_ff         <= bw_in;
         same_ff       <= same_in;
         budget_ff     <= budget_in;
         total_ff      <= total_in;
         missing_ff    <= missing_in;
         has_first_ff  <= has_first_in;
         has_second_ff <= has_second_in;
         pairs_ff      <= pairs_in;
         hv_ff         <= hv_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_acc_ff <= nb_acc_in;
      nbins_ff  <= nbins_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      xi_ff     <= xi_in;
      yi_ff     <= yi_in;
      zi_ff     <= zi_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      maxsq_ff  <= maxsq_in;
      d2_ff     <= d2_in;
      k_ff      <= k_in;
      edge_ff   <= edge_in;
   end

   pdh_mac u_mac (
      .clock   (clock),
      .cmd     (mac_cmd),
      .operand (mac_operand),
      .acc     (mac_acc)
   );

   pdh_ram #(
      .WIDTH (ATOM_W),
      .DEPTH (MAX_ATOMS)
   ) u_atom_ram (
      .clock   (clock),
      .wr_en   (atom_we),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data (atom_wdata),
      .rd_en   (atom_re),
      .rd_addr (atom_raddr),
      .rd_data (atom_rdata)
   );

   pdh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (k_ff),
      .wr_data (hist_wdata),
      .rd_en   (hist_re),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   assign req_port.ready           = (state_ff == S_IDLE);
   assign rsp_port.valid           = (state_ff == S_OUT) || (state_ff == S_ERR);
   assign rsp_port.bin_index       = (state_ff == S_OUT) ? BIN_IDX_W'(k_ff) : '0;
   assign rsp_port.bin_count       = (state_ff == S_OUT) ? hist_value : '0;
   assign rsp_port.status          = (state_ff == S_OUT) ? ST_OK : status_ff;
   assign rsp_port.evaluated_pairs = pairs_ff;
   assign rsp_port.ignored_atoms   = IGNORED_W'(missing_ff);
   assign rsp_port.last            = (state_ff == S_ERR) ||
                                     ((NW'(k_ff) + NW'(1)) == nbins_ff);

endmodule

// ===== hw/rtl/pdh_checker.sv =====
// Port-level assertions of the pair distance histogram unit and their bind.
module pdh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pdh_pkg::BIN_IDX_W-1:0]     rsp_bin_index,
   input logic [pdh_pkg::COUNT_W-1:0]       rsp_bin_count,
   input logic [pdh_pkg::STATUS_W-1:0]      rsp_status,
   input logic [pdh_pkg::COUNT_W-1:0]       rsp_evaluated_pairs,
   input logic                              rsp_last
);
   import pdh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) &&
      $stable(rsp_bin_count) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
      rsp_last && rsp_bin_index == '0 && rsp_bin_count == '0)
      else $error("error result malformed");

   a_err_zero_pairs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BAD_CONFIG || rsp_status == ST_EMPTY ||
      rsp_status == ST_NO_PAIRS) |-> rsp_evaluated_pairs == '0)
      else $error("early error reports evaluated pairs");

endmodule

bind pair_distance_histogram_unit pdh_checker u_pdh_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_port.ready),
   .rsp_valid           (rsp_port.valid),
   .rsp_ready           (rsp_port.ready),
   .rsp_bin_index       (rsp_port.bin_index),
   .rsp_bin_count       (rsp_port.bin_count),
   .rsp_status          (rsp_port.status),
   .rsp_evaluated_pairs (rsp_port.evaluated_pairs),
   .rsp_last            (rsp_port.last)
);

// ===== sim/pdh_checker.sv =====
// Checker for the pair distance histogram unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pdh_scoreboard #(
   parameter int MAX_ATOMS = 1024,
   parameter int MAX_BINS  = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   pdh_req_if                             req,
   pdh_rsp_if                             rsp,
   input  logic                           csr_we,
   input  logic [pdh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pdh_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import pdh_pkg::*;

   typedef struct {
      logic [BIN_IDX_W-1:0] bin_index;
      logic [COUNT_W-1:0]   bin_count;
      pdh_status_type       status;
      logic [COUNT_W-1:0]   evaluated_pairs;
      logic [IGNORED_W-1:0] ignored_atoms;
      logic                 last;
   } bin_result_type;

   bin_result_type expected_bins[$];

   longint              pos_x_store[MAX_ATOMS];
   longint              pos_y_store[MAX_ATOMS];
   longint              pos_z_store[MAX_ATOMS];
   bit                  first_store[MAX_ATOMS];
   bit                  second_store[MAX_ATOMS];
   int unsigned         stored_atoms;
   int unsigned         missing_count;
   logic [RADIUS_W-1:0] radius;
   logic [RADIUS_W-1:0] width;
   logic                same_sel;
   logic [BUDGET_W-1:0] budget;

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 27;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic void push_bin(int unsigned bin, logic [COUNT_W-1:0] cnt,
                                    pdh_status_type st, logic [COUNT_W-1:0] ev, bit last);
      bin_result_type r;
      r.bin_index       = bin[BIN_IDX_W-1:0];
      r.bin_count       = cnt;
      r.status          = st;
      r.evaluated_pairs = ev;
      r.ignored_atoms   = missing_count[IGNORED_W-1:0];
      r.last            = last;
      expected_bins.insert(expected_bins.size(), r);
   endfunction

   function automatic void predict_histogram();
      logic [COUNT_W-1:0] hist[MAX_BINS];
      int unsigned        nbins, b;
      bit                 has_first, has_second;
      longint unsigned    maxsq, d2;
      longint             dx, dy, dz;
      logic [COUNT_W-1:0] pairs;
      pairs      = 0;
      has_first  = 0;
      has_second = 0;
      foreach (hist[k]) hist[k] = 0;
      if (radius == 0 || width == 0 || budget == 0 || width > radius) begin
         push_bin(0, 0, ST_BAD_CONFIG, 0, 1);
         return;
      end
      nbins = (int'(radius) + int'(width) - 1) / int'(width);
      if (nbins > MAX_BINS) begin
         push_bin(0, 0, ST_BAD_CONFIG, 0, 1);
         return;
      end
      for (int i = 0; i < stored_atoms; i++) begin
         has_first  |= first_store[i];
         has_second |= second_store[i];
      end
      if (!has_first || !has_second) begin
         push_bin(0, 0, ST_EMPTY, 0, 1);
         return;
      end
      maxsq = longint'(radius) * longint'(radius);
      for (int i = 0; i < stored_atoms; i++) begin
         if (!first_store[i]) continue;
         for (int j = 0; j < stored_atoms; j++) begin
            if (!second_store[j]) continue;
            if (i == j || (same_sel && i > j)) continue;
            if (pairs >= budget) begin
               push_bin(0, 0, ST_BUDGET, pairs, 1);
               return;
            end
            pairs++;
            dx = pos_x_store[j] - pos_x_store[i];
            dy = pos_y_store[j] - pos_y_store[i];
            dz = pos_z_store[j] - pos_z_store[i];
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < maxsq) begin
               b = int_root(d2) / longint'(width);
               if (b > nbins - 1) b = nbins - 1;
               hist[b]++;
            end
         end
      end
      if (pairs == 0) begin
         push_bin(0, 0, ST_NO_PAIRS, 0, 1);
         return;
      end
      for (int unsigned k = 0; k < nbins; k++)
         push_bin(k, hist[k], ST_OK, pairs, k + 1 == nbins);
   endfunction

   always @(posedge clock) begin
      bin_result_type e;
      if (reset) begin
         stored_atoms  = 0;
         missing_count = 0;
         radius        = MAX_RADIUS_RESET;
         width         = BIN_WIDTH_RESET;
         same_sel      = 1'b0;
         budget        = PAIR_BUDGET_RESET;
         fail_count    = 0;
         expected_bins.delete();
      end else begin
         if (csr_we) begin
            case (pdh_csr_type'(csr_index))
               CSR_MAX_RADIUS:     radius   = csr_wdata[RADIUS_W-1:0];
               CSR_BIN_WIDTH:      width    = csr_wdata[RADIUS_W-1:0];
               CSR_SAME_SELECTION: same_sel = csr_wdata[0];
               CSR_PAIR_BUDGET:    budget   = csr_wdata[BUDGET_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (req.opcode == OP_COMPUTE) begin
               predict_histogram();
               stored_atoms  = 0;
               missing_count = 0;
            end else if (stored_atoms < MAX_ATOMS) begin
               pos_x_store[stored_atoms]  = req.pos_x;
               pos_y_store[stored_atoms]  = req.pos_y;
               pos_z_store[stored_atoms]  = req.pos_z;
               first_store[stored_atoms]  = req.in_first && req.present;
               second_store[stored_atoms] = req.in_second && req.present;
               if ((req.in_first || req.in_second) && !req.present) missing_count++;
               stored_atoms++;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_bins.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: bin %0d count %0d status %0d",
                           rsp.bin_index, rsp.bin_count, rsp.status);
            end else begin
               e = expected_bins.pop_front();
               if (rsp.bin_index !== e.bin_index || rsp.bin_count !== e.bin_count
                   || rsp.status !== e.status || rsp.evaluated_pairs !== e.evaluated_pairs
                   || rsp.ignored_atoms !== e.ignored_atoms || rsp.last !== e.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch exp bin %0d cnt %0d st %0d ev %0d ign %0d ",
                               "last %0d / act bin %0d cnt %0d st %0d ev %0d ign %0d ",
                               "last %0d"},
                              e.bin_index, e.bin_count, e.status, e.evaluated_pairs,
                              e.ignored_atoms, e.last, rsp.bin_index, rsp.bin_count,
                              rsp.status, rsp.evaluated_pairs, rsp.ignored_atoms, rsp.last);
               end
            end
         end
      end
      pending = expected_bins.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the pair distance histogram unit: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
   import pdh_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   bit                    quiet;
   int                    items_sent;
   int unsigned           cur_radius;

   pdh_req_if req_port ();
   pdh_rsp_if rsp_port ();

   pair_distance_histogram_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pdh_scoreboard u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .rsp        (rsp_port),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock)
      rsp_port.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);

   task automatic send(pdh_opcode_type op, int x, int y, int z, int f, int s, int p);
      if (!quiet && $urandom_range(99) < 7) begin
         req_port.valid <= 1'b0;
         @(posedge clock);
      end
      req_port.valid     <= 1'b1;
      req_port.opcode    <= op;
      req_port.pos_x     <= COORD_W'(x);
      req_port.pos_y     <= COORD_W'(y);
      req_port.pos_z     <= COORD_W'(z);
      req_port.in_first  <= f[0];
      req_port.in_second <= s[0];
      req_port.present   <= p[0];
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (pending != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic compute();
      send(OP_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
           $urandom_range(0, 1), $urandom_range(0, 1));
      req_port.valid <= 1'b0;
      wait_idle();
   endtask

   task automatic set_config(int unsigned r, int unsigned w, int unsigned ss,
                             logic [31:0] bud);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_RADIUS;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= CSR_BIN_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_SAME_SELECTION;
      csr_wdata <= {31'd0, ss[0]};
      @(posedge clock);
      csr_index <= CSR_PAIR_BUDGET;
      csr_wdata <= bud;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_radius = r;
   endtask

   task automatic random_frame(int n);
      int cx, cy, cz, spread;
      cx     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      cy     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      cz     = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      spread = (cur_radius / 2 + 1 > (1 << 21)) ? (1 << 21) : cur_radius / 2 + 1;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 10)
            send(OP_LOAD, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
         else
            send(OP_LOAD, cx + int'($urandom_range(0, 2 * spread)) - spread,
                 cy + int'($urandom_range(0, 2 * spread)) - spread,
                 cz + int'($urandom_range(0, 2 * spread)) - spread,
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(99) < 88);
      end
      compute();
   endtask

   task automatic random_config();
      int unsigned r, nb, w;
      logic [31:0] bud;
      case ($urandom_range(0, 9))
         0: r = 0;
         1: r = 8388607;
         default: r = $urandom_range(1, 4000);
      endcase
      nb = $urandom_range(1, 64);
      w  = (r + nb - 1) / nb;
      if (w == 0) w = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) w = r + 1;
      case ($urandom_range(0, 19))
         0: bud = '1;
         1, 2, 3, 4: bud = $urandom_range(0, 30);
         default: bud = $urandom();
      endcase
      set_config(r, w, $urandom_range(0, 1), bud);
   endtask

   initial begin
      int frames;
      reset              = 1'b1;
      quiet              = 1'b0;
      items_sent         = 0;
      cur_radius         = 2560;
      csr_we             = 1'b0;
      csr_index          = CSR_MAX_RADIUS;
      csr_wdata          = '0;
      req_port.valid     = 1'b0;
      req_port.opcode    = OP_LOAD;
      req_port.pos_x     = '0;
      req_port.pos_y     = '0;
      req_port.pos_z     = '0;
      req_port.in_first  = 1'b0;
      req_port.in_second = 1'b0;
      req_port.present   = 1'b0;
      rsp_port.ready     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(OP_LOAD, 0, 0, 0, 1, 1, 1);
      send(OP_LOAD, 256, 0, 0, 1, 1, 1);
      send(OP_LOAD, 700, -300, 90, 1, 1, 1);
      compute();

      set_config(8388607, 8388607, 0, '1);
      send(OP_LOAD, -8388608, -8388608, -8388608, 1, 0, 1);
      send(OP_LOAD, 8388607, 8388607, 8388607, 0, 1, 1);
      send(OP_LOAD, 0, 0, 0, 1, 1, 0);
      send(OP_LOAD, 100, 100, 100, 1, 1, 1);
      compute();

      send(OP_LOAD, 5, 5, 5, 1, 1, 1);
      compute();
      compute();

      set_config(64, 1, 1, 1);
      send(OP_LOAD, 0, 0, 0, 1, 1, 1);
      send(OP_LOAD, 3, 4, 0, 1, 1, 1);
      send(OP_LOAD, 63, 0, 0, 1, 1, 1);
      compute();

      set_config(64, 1, 1, 100);
      send(OP_LOAD, 0, 0, 0, 1, 1, 1);
      send(OP_LOAD, 3, 4, 0, 1, 1, 1);
      send(OP_LOAD, 63, 0, 0, 1, 1, 1);
      compute();

      set_config(0, 256, 0, 1000);
      compute();
      set_config(10, 11, 0, 1000);
      compute();
      set_config(65, 1, 0, 1000);
      compute();
      set_config(2560, 256, 0, 0);
      compute();

      set_config(2560, 256, 0, 1048576);
      frames = 0;
      while (items_sent < 330) begin
         if (frames % 4 == 0) random_config();
         quiet = (items_sent > 150 && items_sent < 230);
         random_frame($urandom_range(0, 14));
         frames++;
      end
      quiet = 1'b0;
      wait_idle();
      if (fail_count == 0 && pending == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
